@@ rtl/core/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, microcode encoding and control program for the modular
// exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int unsigned MEXP_VALUE_WIDTH = 31;
   localparam int unsigned MEXP_EXP_WIDTH   = 32;
   localparam int unsigned MEXP_PROD_WIDTH  = 2 * MEXP_VALUE_WIDTH;
   localparam int unsigned MEXP_REQ_BITS    = MEXP_VALUE_WIDTH + MEXP_EXP_WIDTH;
   localparam int unsigned MEXP_REQ_BYTES   = (MEXP_REQ_BITS + 7) / 8;
   localparam int unsigned MEXP_REQ_WIDTH   = 8 * MEXP_REQ_BYTES;
   localparam int unsigned MEXP_RSP_BYTES   = (MEXP_VALUE_WIDTH + 7) / 8;
   localparam int unsigned MEXP_RSP_WIDTH   = 8 * MEXP_RSP_BYTES;

   // Remainder unit retires two dividend bits per cycle
   localparam int unsigned MEXP_REM_CYCLES  = MEXP_PROD_WIDTH / 2;
   localparam int unsigned MEXP_REM_CNT_W   = $clog2(MEXP_REM_CYCLES + 1);

   localparam logic [MEXP_VALUE_WIDTH-1:0] MEXP_MODULUS_RESET = 31'd1000000007;

   localparam int unsigned MEXP_STEPS    = 14;
   localparam int unsigned MEXP_PC_WIDTH = $clog2(MEXP_STEPS);

   typedef logic [MEXP_PC_WIDTH-1:0] mexp_pc_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_VALID,
      COND_EXP_ZERO,
      COND_BUSY,
      COND_BIT_CLEAR,
      COND_EXP_NZ,
      COND_OUT_FULL,
      COND_ALWAYS
   } mexp_cond_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_DIV_BASE,
      ACT_WB_BASE,
      ACT_MUL_AB,
      ACT_DIV_PROD,
      ACT_WB_ACC,
      ACT_MUL_BB,
      ACT_WB_SQ,
      ACT_OUT_LOAD
   } mexp_act_type;

   // The action fires only when the step falls through (jump not taken)
   typedef struct packed {
      mexp_cond_type cond;
      mexp_pc_type   target;
      mexp_act_type  act;
   } mexp_ctrl_type;

   localparam mexp_pc_type STEP_IDLE = 4'd0;
   localparam mexp_pc_type STEP_LOOP = 4'd4;
   localparam mexp_pc_type STEP_SQ   = 4'd8;
   localparam mexp_pc_type STEP_OUT  = 4'd12;

   function automatic mexp_ctrl_type mexp_rom(input mexp_pc_type pc);
      mexp_ctrl_type word;
      word = '{COND_ALWAYS, STEP_IDLE, ACT_NONE};
      unique case (pc)
         4'd0:    word = '{COND_NO_VALID,  STEP_IDLE, ACT_LOAD};
         4'd1:    word = '{COND_EXP_ZERO,  STEP_OUT,  ACT_NONE};
         4'd2:    word = '{COND_NONE,      STEP_IDLE, ACT_DIV_BASE};
         4'd3:    word = '{COND_BUSY,      4'd3,      ACT_WB_BASE};
         4'd4:    word = '{COND_BIT_CLEAR, STEP_SQ,   ACT_NONE};
         4'd5:    word = '{COND_NONE,      STEP_IDLE, ACT_MUL_AB};
         4'd6:    word = '{COND_NONE,      STEP_IDLE, ACT_DIV_PROD};
         4'd7:    word = '{COND_BUSY,      4'd7,      ACT_WB_ACC};
         4'd8:    word = '{COND_NONE,      STEP_IDLE, ACT_MUL_BB};
         4'd9:    word = '{COND_NONE,      STEP_IDLE, ACT_DIV_PROD};
         4'd10:   word = '{COND_BUSY,      4'd10,     ACT_WB_SQ};
         4'd11:   word = '{COND_EXP_NZ,    STEP_LOOP, ACT_NONE};
         4'd12:   word = '{COND_OUT_FULL,  STEP_OUT,  ACT_OUT_LOAD};
         4'd13:   word = '{COND_ALWAYS,    STEP_IDLE, ACT_NONE};
         default: word = '{COND_ALWAYS,    STEP_IDLE, ACT_NONE};
      endcase
      return word;
   endfunction

endpackage

@@ rtl/core/mexp_rem.sv @@
// ----------------------------------------------------------------------------
// mexp_rem
// Multi-cycle remainder unit: 62-bit dividend modulo a 31-bit modulus,
// restoring, two bits per cycle. A zero modulus gives a zero remainder.
// ----------------------------------------------------------------------------
module mexp_rem (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [mexp_pkg::MEXP_PROD_WIDTH-1:0]  dividend,
   input  logic [mexp_pkg::MEXP_VALUE_WIDTH-1:0] modulus,
   output logic                                  busy,
   output logic [mexp_pkg::MEXP_VALUE_WIDTH-1:0] remainder
);
   import mexp_pkg::*;

   logic                        busy_ff, busy_in;
   logic [MEXP_REM_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MEXP_PROD_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [MEXP_VALUE_WIDTH-1:0] rem_ff, rem_in;

   always_comb begin
      logic [MEXP_VALUE_WIDTH:0]   part;
      logic [MEXP_VALUE_WIDTH-1:0] mid;
      logic [MEXP_VALUE_WIDTH:0]   mod_x;
      mod_x = {1'b0, modulus};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      part    = {rem_ff, dvd_ff[MEXP_PROD_WIDTH-1]};
      if (part >= mod_x) begin
         part = part - mod_x;
      end
      mid  = part[MEXP_VALUE_WIDTH-1:0];
      part = {mid, dvd_ff[MEXP_PROD_WIDTH-2]};
      if (part >= mod_x) begin
         part = part - mod_x;
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MEXP_REM_CNT_W'(MEXP_REM_CYCLES);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[MEXP_PROD_WIDTH-3:0], 2'b00};
         rem_in  = part[MEXP_VALUE_WIDTH-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != MEXP_REM_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = (modulus == '0) ? '0 : rem_ff;

endmodule

@@ rtl/core/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Base to the exponent modulo a programmable modulus, by square-and-multiply
// under a microcoded step sequencer.
// ----------------------------------------------------------------------------
//   channel   direction   handshake               payload
//   req_      in          req_tvalid/req_tready   base_value, exponent
//   rsp_      out         rsp_tvalid/rsp_tready   result
//   csr_      in          csr_valid/csr_ready     modulus
//
// An item has its base reduced first, then per exponent bit a multiply (only
// when the bit is set) and a square, each bound by the two-bit-per-cycle
// remainder unit; the loop ends once the exponent shifts to zero, and a zero
// exponent goes straight to the output. One item is in work at a time; the
// output register lets the next item in while a result waits.
// Reset is synchronous and sets the modulus to 1000000007.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [30:0] base_value, [62:31] exponent, [63] zero fill
   input  logic [mexp_pkg::MEXP_REQ_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [30:0] result, [31] zero fill
   output logic [mexp_pkg::MEXP_RSP_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mexp_pkg::MEXP_VALUE_WIDTH-1:0] csr_data
);
   import mexp_pkg::*;

   mexp_pc_type                 pc_ff, pc_in;
   mexp_ctrl_type               ctrl;
   logic                        taken, fire;

   logic [MEXP_VALUE_WIDTH-1:0] modulus_ff;
   logic [MEXP_VALUE_WIDTH-1:0] base_ff, base_in;
   logic [MEXP_VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [MEXP_EXP_WIDTH-1:0]   exp_ff, exp_in;
   logic [MEXP_PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic [MEXP_VALUE_WIDTH-1:0] mul_a;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [MEXP_VALUE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                        rem_start;
   logic [MEXP_PROD_WIDTH-1:0]  rem_dividend;
   logic                        rem_busy;
   logic [MEXP_VALUE_WIDTH-1:0] rem_value;

   mexp_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .modulus   (modulus_ff),
      .busy      (rem_busy),
      .remainder (rem_value)
   );

   assign ctrl = mexp_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:      taken = 1'b0;
         COND_NO_VALID:  taken = !req_tvalid;
         COND_EXP_ZERO:  taken = (exp_ff == '0);
         COND_BUSY:      taken = rem_busy;
         COND_BIT_CLEAR: taken = !exp_ff[0];
         COND_EXP_NZ:    taken = (exp_ff != '0);
         COND_OUT_FULL:  taken = rsp_valid_ff && !rsp_tready;
         COND_ALWAYS:    taken = 1'b1;
         default:        taken = 1'b1;
      endcase
   end

   assign fire  = !taken;
   assign pc_in = taken ? ctrl.target : mexp_pc_type'(pc_ff + 1'b1);

   assign mul_a   = (ctrl.act == ACT_MUL_AB) ? acc_ff : base_ff;
   assign prod_in = MEXP_PROD_WIDTH'(mul_a) * MEXP_PROD_WIDTH'(base_ff);

   always_comb begin
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rem_start    = 1'b0;
      rem_dividend = prod_ff;
      if (fire) begin
         unique case (ctrl.act)
            ACT_NONE: begin
            end
            ACT_LOAD: begin
               base_in = req_tdata[MEXP_VALUE_WIDTH-1:0];
               exp_in  = req_tdata[MEXP_REQ_BITS-1:MEXP_VALUE_WIDTH];
               acc_in  = MEXP_VALUE_WIDTH'(1);
            end
            ACT_DIV_BASE: begin
               rem_start    = 1'b1;
               rem_dividend = {{MEXP_VALUE_WIDTH{1'b0}}, base_ff};
            end
            ACT_WB_BASE: base_in = rem_value;
            ACT_MUL_AB, ACT_MUL_BB: begin
            end
            ACT_DIV_PROD: rem_start = 1'b1;
            ACT_WB_ACC:   acc_in = rem_value;
            ACT_WB_SQ: begin
               base_in = rem_value;
               exp_in  = exp_ff >> 1;
            end
            ACT_OUT_LOAD: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MEXP_MODULUS_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            modulus_ff <= csr_data;
         end
      end
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
      // hold the product only on multiply steps
      if (ctrl.act == ACT_MUL_AB || ctrl.act == ACT_MUL_BB) begin
         prod_ff <= prod_in;
      end
   end

   assign req_tready = (pc_ff == STEP_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = MEXP_RSP_WIDTH'(rsp_data_ff);
   assign csr_ready  = 1'b1;

endmodule
